// File: rtl/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int HUE_W     = 9;
  localparam int HUE_Q_MIN = 6;

  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 9'd360;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } hue_sector_e;

  typedef struct packed {
    logic        gray;
    logic        neg;
    hue_sector_e sector;
  } hue_ctl_t;

endpackage

// File: rtl/rhc_prep.sv
`timescale 1ns / 1ps

module rhc_prep #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [COMPONENT_BITS-1:0]     red_i,
  input  logic [COMPONENT_BITS-1:0]     green_i,
  input  logic [COMPONENT_BITS-1:0]     blue_i,
  output logic                          valid_o,
  output rhc_pkg::hue_ctl_t             ctl_o,
  output logic [COMPONENT_BITS+5:0]     hue_num_o,
  output logic [2*COMPONENT_BITS-1:0]   sat_num_o,
  output logic [COMPONENT_BITS-1:0]     diff_o,
  output logic [COMPONENT_BITS-1:0]     max_o
);
  import rhc_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int HN_W = CB + 6;
  localparam int SN_W = 2 * CB;

  // stage one: extremes and sector
  logic [CB-1:0] mx, mn, x_sel, y_sel;
  hue_sector_e   sector;

  logic [CB-1:0] x_q, y_q, mx1_q, diff1_q;
  hue_sector_e   sector_q;
  logic          vld1_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    if (mx == red_i) begin
      sector = SEC_RED;
      x_sel  = green_i;
      y_sel  = blue_i;
    end else if (mx == green_i) begin
      sector = SEC_GREEN;
      x_sel  = blue_i;
      y_sel  = red_i;
    end else begin
      sector = SEC_BLUE;
      x_sel  = red_i;
      y_sel  = green_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_sel;
    y_q      <= y_sel;
    mx1_q    <= mx;
    diff1_q  <= mx - mn;
    sector_q <= sector;
  end

  // stage two: difference magnitude and constant scaling
  logic            neg;
  logic [CB-1:0]   absd;
  logic [HN_W-1:0] hnum_d;
  logic [SN_W-1:0] snum_d;
  hue_ctl_t        ctl_d;

  logic            vld2_q;
  hue_ctl_t        ctl_q;
  logic [HN_W-1:0] hnum_q;
  logic [SN_W-1:0] snum_q;
  logic [CB-1:0]   diff2_q, mx2_q;

  always_comb begin
    neg         = x_q < y_q;
    absd        = neg ? (y_q - x_q) : (x_q - y_q);
    hnum_d      = (HN_W'(absd) << 6) - (HN_W'(absd) << 2);
    snum_d      = (SN_W'(diff1_q) << CB) - SN_W'(diff1_q);
    ctl_d.gray  = diff1_q == '0;
    ctl_d.neg   = neg;
    ctl_d.sector = sector_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q   <= ctl_d;
    hnum_q  <= hnum_d;
    snum_q  <= snum_d;
    diff2_q <= diff1_q;
    mx2_q   <= mx1_q;
  end

  assign valid_o   = vld2_q;
  assign ctl_o     = ctl_q;
  assign hue_num_o = hnum_q;
  assign sat_num_o = snum_q;
  assign diff_o    = diff2_q;
  assign max_o     = mx2_q;

endmodule

// File: rtl/rhc_div.sv
`timescale 1ns / 1ps

module rhc_div #(
  parameter int NUM_W  = 14,
  parameter int DEN_W  = 8,
  parameter int Q_W    = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic              rem_nz_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]     rem_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic [Q_W-1:0]    vld_q;

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int Pos = Q_W - 1 - s;

    logic [RW-1:0]     rem_in, trial, rem_d;
    logic [Q_W-1:0]    quo_in, quo_d;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic              take;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(num_i);
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign trial = RW'(den_in) << Pos;
    assign take  = rem_in >= trial;
    assign rem_d = take ? (rem_in - trial) : rem_in;

    always_comb begin
      quo_d      = quo_in;
      quo_d[Pos] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      quo_q[s]  <= quo_d;
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o  = vld_q[Q_W-1];
  assign quo_o    = quo_q[Q_W-1];
  assign rem_nz_o = |rem_q[Q_W-1];
  assign side_o   = side_q[Q_W-1];

endmodule

// File: rtl/rgb_to_hsv_converter_core.sv
`timescale 1ns / 1ps
// channel  | direction | handshake        | fields
// ---------+-----------+------------------+--------------------------------------
// pixel    | in        | start_i, busy_o  | red_i, green_i, blue_i
// hsv      | out       | done_o (strobe)  | hue_o, saturation_o, brightness_o
//
// one pixel accepted per clock; busy_o is never raised
// results pass through the preparation stages of rhc_prep, the two restoring dividers
// that resolve one quotient bit per stage, and a final output register
// reset clears only the valid bits of the pipeline; no clearing pass
// results leave on done_o for one cycle and cannot be held off

module rgb_to_hsv_converter_core #(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [COMPONENT_BITS-1:0]  red_i,
  input  logic [COMPONENT_BITS-1:0]  green_i,
  input  logic [COMPONENT_BITS-1:0]  blue_i,
  output logic                       done_o,
  output logic [rhc_pkg::HUE_W-1:0]  hue_o,
  output logic [COMPONENT_BITS-1:0]  saturation_o,
  output logic [COMPONENT_BITS-1:0]  brightness_o
);
  import rhc_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int QW   = (CB > HUE_Q_MIN) ? CB : HUE_Q_MIN;
  localparam int HN_W = CB + 6;
  localparam int SN_W = 2 * CB;
  localparam int CTL_W = $bits(hue_ctl_t);

  logic            prep_vld;
  hue_ctl_t        prep_ctl;
  logic [HN_W-1:0] prep_hnum;
  logic [SN_W-1:0] prep_snum;
  logic [CB-1:0]   prep_diff, prep_max;

  rhc_prep #(
    .COMPONENT_BITS(CB)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .valid_o  (prep_vld),
    .ctl_o    (prep_ctl),
    .hue_num_o(prep_hnum),
    .sat_num_o(prep_snum),
    .diff_o   (prep_diff),
    .max_o    (prep_max)
  );

  logic             hdiv_vld;
  logic [QW-1:0]    hdiv_quo;
  logic             hdiv_nz;
  logic [CTL_W-1:0] hdiv_side;
  logic [QW-1:0]    sdiv_quo;
  logic [CB-1:0]    sdiv_max;

  rhc_div #(
    .NUM_W (HN_W),
    .DEN_W (CB),
    .Q_W   (QW),
    .SIDE_W(CTL_W)
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .num_i   (prep_hnum),
    .den_i   (prep_diff),
    .side_i  (prep_ctl),
    .valid_o (hdiv_vld),
    .quo_o   (hdiv_quo),
    .rem_nz_o(hdiv_nz),
    .side_o  (hdiv_side)
  );

  rhc_div #(
    .NUM_W (SN_W),
    .DEN_W (CB),
    .Q_W   (QW),
    .SIDE_W(CB)
  ) u_sat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .num_i   (prep_snum),
    .den_i   (prep_max),
    .side_i  (prep_max),
    .valid_o (),
    .quo_o   (sdiv_quo),
    .rem_nz_o(),
    .side_o  (sdiv_max)
  );

  // final stage: place the offset in its sector and register saturation and brightness
  hue_ctl_t         ctl;
  logic [HUE_W-1:0] q_h, ceil_h, base_h, hue_d;
  logic [CB-1:0]    sat_d;

  logic             done_q;
  logic [HUE_W-1:0] hue_q;
  logic [CB-1:0]    sat_q, bright_q;

  always_comb begin
    ctl    = hue_ctl_t'(hdiv_side);
    q_h    = HUE_W'(hdiv_quo);
    ceil_h = q_h + HUE_W'(hdiv_nz);
    case (ctl.sector)
      SEC_RED:   base_h = HUE_BASE_RED;
      SEC_GREEN: base_h = HUE_BASE_GREEN;
      SEC_BLUE:  base_h = HUE_BASE_BLUE;
      default:   base_h = HUE_BASE_RED;
    endcase
    if (ctl.gray) begin
      hue_d = '0;
    end else if (!ctl.neg) begin
      hue_d = base_h + q_h;
    end else if (ctl.sector == SEC_RED) begin
      hue_d = HUE_FULL_TURN - ceil_h;
    end else begin
      hue_d = base_h - ceil_h;
    end
    sat_d = (sdiv_max == '0) ? '0 : CB'(sdiv_quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= hdiv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    bright_q <= sdiv_max;
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

// File: rtl/rhc_checker.sv
`timescale 1ns / 1ps

module rhc_checker #(
  parameter int COMPONENT_BITS = 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic [COMPONENT_BITS-1:0]  red_i,
  input logic [COMPONENT_BITS-1:0]  green_i,
  input logic [COMPONENT_BITS-1:0]  blue_i,
  input logic                       done_o,
  input logic [rhc_pkg::HUE_W-1:0]  hue_o,
  input logic [COMPONENT_BITS-1:0]  saturation_o,
  input logic [COMPONENT_BITS-1:0]  brightness_o
);
  import rhc_pkg::*;

  localparam int QW      = (COMPONENT_BITS > HUE_Q_MIN) ? COMPONENT_BITS : HUE_Q_MIN;
  localparam int LATENCY = QW + 3;

  logic [COMPONENT_BITS-1:0] pix_or;
  assign pix_or = red_i | green_i | blue_i;

  a_beat_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted beat did not produce a result");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without an accepted beat");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_o < HUE_FULL_TURN))
    else $error("hue out of range");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && brightness_o == '0) |-> (saturation_o == '0 && hue_o == '0))
    else $error("black pixel with colour");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturation_o == '0 && pix_or == pix_or) |-> (hue_o == '0))
    else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rhc_checker #(
  .COMPONENT_BITS(COMPONENT_BITS)
) u_rhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .red_i       (red_i),
  .green_i     (green_i),
  .blue_i      (blue_i),
  .done_o      (done_o),
  .hue_o       (hue_o),
  .saturation_o(saturation_o),
  .brightness_o(brightness_o)
);
